### hw/rtl/circular_deque_unit_macros.svh
// ----------------------------------------------------------------------------
// Circular deque unit assertion macros
// Shared property wrappers for the deque RTL; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_UNIT_MACROS_SVH
`define CIRCULAR_DEQUE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define CDQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("circular deque assertion failed");

// next-cycle implication
`define CDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("circular deque assertion failed");

`else

`define CDQ_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CDQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// Circular deque package
// Widths, operation codes, controller states and command bundle.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam int MAX_DEPTH_DEF = 16;
   localparam int DATA_W        = 32;
   localparam int FUNC_W        = 2;
   localparam int CSR_W         = 5;

   // capacity register value after reset
   localparam logic [CSR_W-1:0]  CAP_RESET   = 5'd16;
   // front/rear value reported for an empty deque
   localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INS_FRONT = 2'd0,
      FUNC_INS_BACK  = 2'd1,
      FUNC_REM_FRONT = 2'd2,
      FUNC_REM_BACK  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_FETCH = 2'd1,
      ST_LOAD  = 2'd2
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic exec;       // beat accepted: update pointers, write store
      logic fetch;      // read front and rear entries
      logic load;       // load output register
      logic cfg_write;  // capacity write, empties the deque
   } cmd_type;

endpackage

### hw/rtl/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// Circular deque controller
// Sequences accept, store read and output load; owns the output valid flag.
// ----------------------------------------------------------------------------
module cdq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic             csr_valid,
   output logic             csr_ready,
   output cdq_pkg::cmd_type cmd
);

   cdq_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   // output register can take a new beat
   assign out_free = !rsp_valid_ff || rsp_ready;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cdq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cdq_pkg::ST_IDLE: begin
            if (req_valid) state_in = cdq_pkg::ST_FETCH;
         end
         cdq_pkg::ST_FETCH: begin
            state_in = cdq_pkg::ST_LOAD;
         end
         cdq_pkg::ST_LOAD: begin
            if (out_free) state_in = cdq_pkg::ST_IDLE;
         end
         default: begin
            state_in = cdq_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = 1'b0;
      cmd.exec      = 1'b0;
      cmd.fetch     = 1'b0;
      cmd.load      = 1'b0;
      cmd.cfg_write = csr_valid;
      case (state_ff)
         cdq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.exec  = req_valid;
         end
         cdq_pkg::ST_FETCH: begin
            cmd.fetch = 1'b1;
         end
         cdq_pkg::ST_LOAD: begin
            cmd.load = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // output valid: set on load, cleared when the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load)       rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;
   assign csr_ready = 1'b1;

endmodule

### hw/rtl/cdq_datapath.sv
// ----------------------------------------------------------------------------
// Circular deque datapath
// Ring store, head/tail pointers, occupancy, capacity register, output register.
// ----------------------------------------------------------------------------
module cdq_datapath #(
   parameter int MAX_DEPTH = cdq_pkg::MAX_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cdq_pkg::cmd_type                 cmd,
   input  logic [cdq_pkg::FUNC_W-1:0]       req_func,
   input  logic signed [cdq_pkg::DATA_W-1:0] req_data_value,
   input  logic [cdq_pkg::CSR_W-1:0]        csr_capacity_in_use,
   output logic                             rsp_accepted,
   output logic signed [cdq_pkg::DATA_W-1:0] rsp_front_value,
   output logic signed [cdq_pkg::DATA_W-1:0] rsp_rear_value,
   output logic                             rsp_is_empty,
   output logic                             rsp_is_full
);

   localparam int PTR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int CNT_W = $clog2(MAX_DEPTH + 1) > 0 ? $clog2(MAX_DEPTH + 1) : 1;
   localparam int CAP_W = (CNT_W > cdq_pkg::CSR_W) ? CNT_W : cdq_pkg::CSR_W;

   logic [cdq_pkg::DATA_W-1:0] store [MAX_DEPTH];

   logic [cdq_pkg::CSR_W-1:0]  cap_ff;
   logic [PTR_W-1:0]           head_ff, head_in;
   logic [PTR_W-1:0]           tail_ff, tail_in;
   logic [CNT_W-1:0]           occ_ff, occ_in;
   logic                       ok_ff, ok_in;
   logic [cdq_pkg::DATA_W-1:0] front_rd_ff, rear_rd_ff;

   logic [CAP_W-1:0]           cap_wide;
   logic [CNT_W-1:0]           eff_cap;
   logic [PTR_W-1:0]           last_idx;
   logic [CNT_W-1:0]           head_inc, tail_inc;
   logic [PTR_W-1:0]           head_back, head_fwd, tail_back, tail_fwd;
   logic                       has_room, has_item;
   logic                       wr_en;
   logic [PTR_W-1:0]           wr_addr;
   cdq_pkg::func_type          func;
   logic                       empty_now;

   // effective capacity: zero acts as one, clamp at built depth
   always_comb begin
      cap_wide = CAP_W'(cap_ff);
      if (cap_wide == '0)
         eff_cap = CNT_W'(1);
      else if (cap_wide > CAP_W'(MAX_DEPTH))
         eff_cap = CNT_W'(MAX_DEPTH);
      else
         eff_cap = CNT_W'(cap_wide);
   end

   // ring pointer steps, wrapping at the effective capacity
   assign last_idx  = PTR_W'(eff_cap - CNT_W'(1));
   assign head_inc  = CNT_W'(head_ff) + CNT_W'(1);
   assign tail_inc  = CNT_W'(tail_ff) + CNT_W'(1);
   assign head_back = (head_ff == '0) ? last_idx : head_ff - PTR_W'(1);
   assign tail_back = (tail_ff == '0) ? last_idx : tail_ff - PTR_W'(1);
   assign head_fwd  = (head_inc >= eff_cap) ? '0 : PTR_W'(head_inc);
   assign tail_fwd  = (tail_inc >= eff_cap) ? '0 : PTR_W'(tail_inc);

   assign has_room  = (occ_ff < eff_cap);
   assign has_item  = (occ_ff != '0);
   assign func      = cdq_pkg::func_type'(req_func);
   assign empty_now = (occ_ff == '0);

   // operation decode
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      occ_in  = occ_ff;
      ok_in   = 1'b0;
      wr_en   = 1'b0;
      wr_addr = head_back;
      case (func)
         cdq_pkg::FUNC_INS_FRONT: begin
            if (has_room) begin
               head_in = head_back;
               wr_en   = 1'b1;
               wr_addr = head_back;
               occ_in  = occ_ff + CNT_W'(1);
               ok_in   = 1'b1;
            end
         end
         cdq_pkg::FUNC_INS_BACK: begin
            if (has_room) begin
               tail_in = tail_fwd;
               wr_en   = 1'b1;
               wr_addr = tail_ff;
               occ_in  = occ_ff + CNT_W'(1);
               ok_in   = 1'b1;
            end
         end
         cdq_pkg::FUNC_REM_FRONT: begin
            if (has_item) begin
               head_in = head_fwd;
               occ_in  = occ_ff - CNT_W'(1);
               ok_in   = 1'b1;
            end
         end
         cdq_pkg::FUNC_REM_BACK: begin
            if (has_item) begin
               tail_in = tail_back;
               occ_in  = occ_ff - CNT_W'(1);
               ok_in   = 1'b1;
            end
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   // pointer, count and capacity registers; capacity write empties the deque
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= cdq_pkg::CAP_RESET;
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
      end else if (cmd.cfg_write) begin
         cap_ff  <= csr_capacity_in_use;
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
      end else if (cmd.exec) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
      end
   end

   // success flag of the beat in flight
   always_ff @(posedge clock) begin
      if (cmd.exec) ok_ff <= ok_in;
   end

   // ring store write port
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) store[wr_addr] <= $unsigned(req_data_value);
   end

   // ring store read ports: front at head, rear just before tail
   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         front_rd_ff <= store[head_ff];
         rear_rd_ff  <= store[tail_back];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_accepted    <= ok_ff;
         rsp_front_value <= signed'(empty_now ? cdq_pkg::EMPTY_VALUE : front_rd_ff);
         rsp_rear_value  <= signed'(empty_now ? cdq_pkg::EMPTY_VALUE : rear_rd_ff);
         rsp_is_empty    <= empty_now;
         rsp_is_full     <= (occ_ff == eff_cap);
      end
   end

endmodule

### hw/rtl/circular_deque_unit.sv
// ----------------------------------------------------------------------------
// Circular deque unit
// Double-ended queue in a ring store with a run-time capacity limit.
// ----------------------------------------------------------------------------
// Each request beat runs through accept, fetch and load: the accept edge updates
// the pointers and writes the ring store, the next cycle reads the front and rear
// entries through the store's registered read ports, and the load step loads the
// result register. The result register frees the response side, so the next
// request is taken while a result waits; the load step stalls only while a
// previous result is still held. A capacity write empties the deque and must be
// issued while no operation is in flight. No reset sweep is needed.
`include "circular_deque_unit_macros.svh"

module circular_deque_unit #(
   parameter int MAX_DEPTH = cdq_pkg::MAX_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [cdq_pkg::FUNC_W-1:0]        req_func,
   input  logic signed [cdq_pkg::DATA_W-1:0] req_data_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_accepted,
   output logic signed [cdq_pkg::DATA_W-1:0] rsp_front_value,
   output logic signed [cdq_pkg::DATA_W-1:0] rsp_rear_value,
   output logic                              rsp_is_empty,
   output logic                              rsp_is_full,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cdq_pkg::CSR_W-1:0]         csr_capacity_in_use
);

   cdq_pkg::cmd_type cmd;

   // sequencer
   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   // store, pointers and result register
   cdq_datapath #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_func            (req_func),
      .req_data_value      (req_data_value),
      .csr_capacity_in_use (csr_capacity_in_use),
      .rsp_accepted        (rsp_accepted),
      .rsp_front_value     (rsp_front_value),
      .rsp_rear_value      (rsp_rear_value),
      .rsp_is_empty        (rsp_is_empty),
      .rsp_is_full         (rsp_is_full)
   );

   // an accepted beat keeps the request side busy for its store read
   `CDQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // empty result carries the sentinel on both ends
   `CDQ_ASSERT_IMPL(a_empty_sentinel, clock, reset, rsp_valid && rsp_is_empty, (rsp_front_value == -32'sd1) && (rsp_rear_value == -32'sd1))

   // capacity is at least one, so empty and full never coincide
   `CDQ_ASSERT_IMPL(a_empty_not_full, clock, reset, rsp_valid && rsp_is_empty, !rsp_is_full)

endmodule
